[hw/rtl/fma_pkg.sv]
// Shared types and constants for the fault monitor aggregator.
// Holds the transaction structs, op codes, fault bit positions and register indexes.
// No dependencies.
`default_nettype none

package fma_pkg;

    // Sizes
    localparam int NUM_FAULTS  = 6;
    localparam int COUNT_WIDTH = 32;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    // Op codes
    localparam logic [2:0] OP_RAISE     = 3'd0;
    localparam logic [2:0] OP_CLEAR     = 3'd1;
    localparam logic [2:0] OP_TICK      = 3'd2;
    localparam logic [2:0] OP_PHY_CHECK = 3'd3;
    localparam logic [2:0] OP_READ_CNT  = 3'd4;

    // Fault bit positions
    localparam int FB_CONFIG  = 0;
    localparam int FB_BUS     = 1;
    localparam int FB_LINK    = 2;
    localparam int FB_OVERRUN = 3;
    localparam int FB_TEMP    = 4;
    localparam int FB_PHY     = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINK_GRACE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERTEMP_LIM = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHY_ID_HIGH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHY_ID_LOW   = 8'd3;

    // Register reset values
    localparam logic [31:0] LINK_GRACE_RST   = 32'd3000;
    localparam logic [11:0] OVERTEMP_LIM_RST = 12'd763;
    localparam logic [15:0] PHY_ID_HIGH_RST  = 16'h0022;
    localparam logic [15:0] PHY_ID_LOW_RST   = 16'h1620;

    // Low nibble of the second PHY word is a revision field and is ignored
    localparam logic [15:0] PHY_LOW_MASK = 16'hFFF0;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  fault_mask;
        logic        link_up;
        logic [31:0] dropped_count;
        logic [11:0] temp_code;
        logic [31:0] now_ms;
        logic [15:0] phy_word_high;
        logic [15:0] phy_word_low;
        logic [2:0]  counter_index;
    } fma_in_t;

    typedef struct packed {
        logic [5:0]             active_faults;
        logic [5:0]             latched_faults;
        logic                   phy_ok;
        logic [COUNT_WIDTH-1:0] counter_value;
        logic [11:0]            last_temp_code;
    } fma_out_t;

    typedef struct packed {
        logic [31:0] link_grace_ms;
        logic [11:0] overtemp_raw_limit;
        logic [15:0] phy_id_high_expected;
        logic [15:0] phy_id_low_expected;
    } fma_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/fault_monitor_aggregator_top.sv]
// Top level of the fault monitor aggregator: input register, result register
// and handshakes. Depends on fma_pkg, fma_cfg_regs and fma_core.
//
//  Channel   Ports                                Direction  Moves
//  --------  -----------------------------------  ---------  -------------------------
//  input     s_valid  s_ready  s_data             in         one fma_in_t per transaction
//  result    m_valid  m_ready  m_data             out        one fma_out_t per transaction
//  config    cfg_valid cfg_ready cfg_index cfg_data in       one register write
//
// One result per input transaction; each passes through the input register, then the
// single-pass update into the result register.
// Sustained rate is one transaction per cycle while m_ready is high; the fault
// state is updated in the same cycle the result is computed, so back-to-back items
// see it at once. A stalled result holds the pipe; s_ready drops only when both
// registers are full and m_ready is low.
// Synchronous active-low reset clears all fault state, counters and valid flags.
`default_nettype none

module fault_monitor_aggregator_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire fma_pkg::fma_in_t              s_data,
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output fma_pkg::fma_out_t                  m_data,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [fma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fma_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fma_pkg::*;

    fma_in_t  in_reg;
    logic     in_valid_reg;
    fma_out_t out_reg;
    logic     out_valid_reg;
    fma_out_t result;
    fma_cfg_t cfg;
    logic     advance;

    // Move the held item into the result register when that slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    fma_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fma_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

[hw/rtl/fma_cfg_regs.sv]
// Configuration register file for the fault monitor aggregator.
// Depends on fma_pkg for the register indexes, reset values and fma_cfg_t.
`default_nettype none

module fma_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [fma_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [fma_pkg::CFG_DATA_W-1:0] wr_data,
    output fma_pkg::fma_cfg_t                  cfg
);
    import fma_pkg::*;

    fma_cfg_t cfg_reg;
    fma_cfg_t cfg_next;

    // Decode the write; out-of-range indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_LINK_GRACE:   cfg_next.link_grace_ms        = wr_data;
                REG_OVERTEMP_LIM: cfg_next.overtemp_raw_limit   = wr_data[11:0];
                REG_PHY_ID_HIGH:  cfg_next.phy_id_high_expected = wr_data[15:0];
                REG_PHY_ID_LOW:   cfg_next.phy_id_low_expected  = wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.link_grace_ms        <= LINK_GRACE_RST;
            cfg_reg.overtemp_raw_limit   <= OVERTEMP_LIM_RST;
            cfg_reg.phy_id_high_expected <= PHY_ID_HIGH_RST;
            cfg_reg.phy_id_low_expected  <= PHY_ID_LOW_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hw/rtl/fma_core.sv]
// Fault state and per-item update logic: active/latched bits, event counters,
// link-down timer, drop tracking and stored temperature. Depends on fma_pkg.
`default_nettype none

module fma_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire fma_pkg::fma_in_t  item,
    input  wire fma_pkg::fma_cfg_t cfg,
    output fma_pkg::fma_out_t      result
);
    import fma_pkg::*;

    logic [5:0]             active_reg,    active_next;
    logic [5:0]             latched_reg,   latched_next;
    logic [COUNT_WIDTH-1:0] count_reg [NUM_FAULTS];
    logic [31:0]            down_start_reg, down_start_next;
    logic                   down_seen_reg,  down_seen_next;
    logic [31:0]            prev_drop_reg,  prev_drop_next;
    logic [11:0]            temp_reg,       temp_next;
    logic [NUM_FAULTS-1:0]  inc;
    logic [5:0]             mask;
    logic [5:0]             lowest;
    logic [31:0]            down_time;
    logic                   phy_match;
    logic                   phy_ok;
    logic [COUNT_WIDTH-1:0] cval;

    assign mask      = item.fault_mask;
    assign lowest    = mask & (~mask + 6'd1);
    assign down_time = item.now_ms - down_start_reg;
    assign phy_match = (item.phy_word_high == cfg.phy_id_high_expected) &&
                       ((item.phy_word_low & PHY_LOW_MASK) ==
                        (cfg.phy_id_low_expected & PHY_LOW_MASK));

    // One pass over the item against current state
    always_comb begin
        active_next     = active_reg;
        latched_next    = latched_reg;
        down_start_next = down_start_reg;
        down_seen_next  = down_seen_reg;
        prev_drop_next  = prev_drop_reg;
        temp_next       = temp_reg;
        inc             = '0;
        phy_ok          = 1'b0;
        cval            = '0;
        case (item.op)
            OP_RAISE: begin
                if (mask != 6'd0) begin
                    // count only a fresh raise, against the lowest bit
                    if ((active_reg & mask) == 6'd0) begin
                        inc = lowest;
                    end
                    active_next  = active_reg | mask;
                    latched_next = latched_reg | mask;
                end
            end
            OP_CLEAR: begin
                active_next = active_reg & ~mask;
            end
            OP_TICK: begin
                temp_next = item.temp_code;
                // overtemperature: low code means hot
                if (item.temp_code <= cfg.overtemp_raw_limit) begin
                    inc[FB_TEMP]          = ~active_reg[FB_TEMP];
                    active_next[FB_TEMP]  = 1'b1;
                    latched_next[FB_TEMP] = 1'b1;
                end else begin
                    active_next[FB_TEMP] = 1'b0;
                end
                // link-down with grace time
                if (item.link_up) begin
                    down_seen_next       = 1'b0;
                    active_next[FB_LINK] = 1'b0;
                end else if (!down_seen_reg) begin
                    down_seen_next  = 1'b1;
                    down_start_next = item.now_ms;
                end else if (down_time > cfg.link_grace_ms) begin
                    inc[FB_LINK]          = ~active_reg[FB_LINK];
                    active_next[FB_LINK]  = 1'b1;
                    latched_next[FB_LINK] = 1'b1;
                end
                // overrun when the drop counter moved
                if (item.dropped_count != prev_drop_reg) begin
                    inc[FB_OVERRUN]          = ~active_reg[FB_OVERRUN];
                    active_next[FB_OVERRUN]  = 1'b1;
                    latched_next[FB_OVERRUN] = 1'b1;
                    prev_drop_next           = item.dropped_count;
                end else begin
                    active_next[FB_OVERRUN] = 1'b0;
                end
            end
            OP_PHY_CHECK: begin
                if (phy_match) begin
                    phy_ok = 1'b1;
                end else begin
                    inc[FB_PHY]          = ~active_reg[FB_PHY];
                    active_next[FB_PHY]  = 1'b1;
                    latched_next[FB_PHY] = 1'b1;
                end
            end
            OP_READ_CNT: begin
                if (32'(item.counter_index) < NUM_FAULTS) begin
                    cval = count_reg[item.counter_index];
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= '0;
            latched_reg    <= '0;
            down_start_reg <= '0;
            down_seen_reg  <= 1'b0;
            prev_drop_reg  <= '0;
            temp_reg       <= '0;
        end else if (advance) begin
            active_reg     <= active_next;
            latched_reg    <= latched_next;
            down_start_reg <= down_start_next;
            down_seen_reg  <= down_seen_next;
            prev_drop_reg  <= prev_drop_next;
            temp_reg       <= temp_next;
        end
    end

    // Per-fault wrapping event counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_FAULTS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (advance) begin
            for (int i = 0; i < NUM_FAULTS; i++) begin
                if (inc[i]) begin
                    count_reg[i] <= count_reg[i] + 1'b1;
                end
            end
        end
    end

    assign result.active_faults  = active_next;
    assign result.latched_faults = latched_next;
    assign result.phy_ok         = phy_ok;
    assign result.counter_value  = cval;
    assign result.last_temp_code = temp_next;

endmodule

`default_nettype wire

[hw/rtl/fma_checker.sv]
// Port-level checker for the fault monitor aggregator, bound to the top level.
// Depends on fma_pkg for the transaction structs.
`default_nettype none

module fma_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire fma_pkg::fma_out_t m_data
);
    import fma_pkg::*;

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the result side
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Every active fault is also latched
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.active_faults & ~m_data.latched_faults) == 6'd0)
        else $error("active fault not latched");

    // PHY result and counter read never come from the same transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.phy_ok |-> m_data.counter_value == '0)
        else $error("phy_ok with nonzero counter value");

    // Latched faults never drop between consecutive results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid |->
            (($past(m_data.latched_faults) & ~m_data.latched_faults) == 6'd0))
        else $error("latched fault cleared");

endmodule

bind fault_monitor_aggregator_top fma_checker u_fma_checker (.*);

`default_nettype wire

[verif/fault_monitor_aggregator_top_test.sv]
// Self-checking testbench for fault_monitor_aggregator_top: drives raise, clear, tick,
// PHY check and counter read transactions and checks every report against a predictor.
// Depends on fma_pkg and the RTL of fault_monitor_aggregator_top.

module fault_monitor_aggregator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fma_pkg::*;

    typedef logic [NUM_FAULTS-1:0] fault_set_t;

    localparam fault_set_t ALL_FAULTS     = '1;
    localparam fault_set_t CONFIG_FAULT   = fault_set_t'(1 << FB_CONFIG);
    localparam fault_set_t BUS_FAULT      = fault_set_t'(1 << FB_BUS);
    localparam fault_set_t LINK_FAULT     = fault_set_t'(1 << FB_LINK);
    localparam fault_set_t OVERRUN_FAULT  = fault_set_t'(1 << FB_OVERRUN);
    localparam fault_set_t TEMP_FAULT     = fault_set_t'(1 << FB_TEMP);
    localparam fault_set_t PHY_FAULT      = fault_set_t'(1 << FB_PHY);

    // Op codes the block decodes as no-ops
    localparam logic [2:0] OP_SPARE_FIRST = OP_READ_CNT + 3'd1;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int TEMP_CODE_MAX  = 4095;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 40;
    localparam int STALL_LIMIT    = 1000;
    localparam int PHASE_ITEMS    = 150;
    localparam int BURST_ITEMS    = 30;

    // Predicts each fault report and matches it against what comes out
    class fault_report_board;
        fma_cfg_t          regs;
        fault_set_t        active_bits;
        fault_set_t        latched_bits;
        logic [COUNT_WIDTH-1:0] event_count [NUM_FAULTS];
        logic [31:0]       down_since;
        logic              down_seen;
        logic [31:0]       seen_drop_count;
        logic [11:0]       last_temp;
        fma_out_t          expected_reports [$];
        int                errors;
        int                reports_seen;

        function new();
            regs.link_grace_ms        = LINK_GRACE_RST;
            regs.overtemp_raw_limit   = OVERTEMP_LIM_RST;
            regs.phy_id_high_expected = PHY_ID_HIGH_RST;
            regs.phy_id_low_expected  = PHY_ID_LOW_RST;
            active_bits  = '0;
            latched_bits = '0;
            foreach (event_count[i]) event_count[i] = '0;
            down_since   = '0;
            down_seen    = 1'b0;
            seen_drop_count = '0;
            last_temp    = '0;
            errors       = 0;
            reports_seen = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LINK_GRACE:   regs.link_grace_ms        = data[31:0];
                REG_OVERTEMP_LIM: regs.overtemp_raw_limit   = data[11:0];
                REG_PHY_ID_HIGH:  regs.phy_id_high_expected = data[15:0];
                REG_PHY_ID_LOW:   regs.phy_id_low_expected  = data[15:0];
                default: ;
            endcase
        endfunction

        // An event is counted only when none of the mask was already active
        function void raise_faults(fault_set_t m);
            int low;
            low = 0;
            if (m == '0) return;
            if ((active_bits & m) == '0) begin
                for (int b = NUM_FAULTS - 1; b >= 0; b--)
                    if (m[b]) low = b;
                event_count[low] = event_count[low] + 1'b1;
            end
            active_bits  |= m;
            latched_bits |= m;
        endfunction

        function fma_out_t predict_report(fma_in_t it);
            fma_out_t    r;
            logic [31:0] elapsed;
            r = '0;
            case (it.op)
                OP_RAISE: raise_faults(it.fault_mask);
                OP_CLEAR: active_bits &= ~it.fault_mask;
                OP_TICK: begin
                    last_temp = it.temp_code;
                    if (it.temp_code <= regs.overtemp_raw_limit) raise_faults(TEMP_FAULT);
                    else active_bits &= ~TEMP_FAULT;
                    elapsed = it.now_ms - down_since;
                    if (it.link_up) begin
                        down_seen = 1'b0;
                        active_bits &= ~LINK_FAULT;
                    end else if (!down_seen) begin
                        down_seen  = 1'b1;
                        down_since = it.now_ms;
                    end else if (elapsed > regs.link_grace_ms) begin
                        raise_faults(LINK_FAULT);
                    end
                    if (it.dropped_count != seen_drop_count) begin
                        raise_faults(OVERRUN_FAULT);
                        seen_drop_count = it.dropped_count;
                    end else begin
                        active_bits &= ~OVERRUN_FAULT;
                    end
                end
                OP_PHY_CHECK: begin
                    if (it.phy_word_high == regs.phy_id_high_expected &&
                        (it.phy_word_low & PHY_LOW_MASK) ==
                        (regs.phy_id_low_expected & PHY_LOW_MASK))
                        r.phy_ok = 1'b1;
                    else
                        raise_faults(PHY_FAULT);
                end
                OP_READ_CNT: begin
                    if (it.counter_index < NUM_FAULTS)
                        r.counter_value = event_count[it.counter_index];
                end
                default: ;
            endcase
            r.active_faults  = active_bits;
            r.latched_faults = latched_bits;
            r.last_temp_code = last_temp;
            return r;
        endfunction

        function void note_item(fma_in_t it);
            expected_reports.push_back(predict_report(it));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("report %0d: %s expected %0h, got %0h",
                             reports_seen, name, want, got);
            end
        endfunction

        function void check_report(fma_out_t got);
            fma_out_t want;
            reports_seen++;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("report %0d: nothing expected, got %h", reports_seen, got);
                return;
            end
            want = expected_reports.pop_front();
            compare_field("active_faults", want.active_faults, got.active_faults);
            compare_field("latched_faults", want.latched_faults, got.latched_faults);
            compare_field("phy_ok", want.phy_ok, got.phy_ok);
            compare_field("counter_value", want.counter_value, got.counter_value);
            compare_field("last_temp_code", want.last_temp_code, got.last_temp_code);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void close_out();
            if (expected_reports.size() != 0) begin
                errors += expected_reports.size();
                $display("%0d reports never arrived", expected_reports.size());
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    fma_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    fma_out_t              m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fault_report_board board;
    int                rx_stall_max = 3;
    int                rx_hold_cycles = 0;
    logic [31:0]       gen_clock;
    logic [31:0]       gen_dropped;

    fault_monitor_aggregator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Item with every field random except the op
    function automatic fma_in_t base_item(logic [2:0] op);
        fma_in_t it;
        it.op            = op;
        it.fault_mask    = 6'($urandom);
        it.link_up       = 1'($urandom);
        it.dropped_count = $urandom;
        it.temp_code     = 12'($urandom);
        it.now_ms        = $urandom;
        it.phy_word_high = 16'($urandom);
        it.phy_word_low  = 16'($urandom);
        it.counter_index = 3'($urandom);
        return it;
    endfunction

    function automatic fma_in_t mask_item(logic [2:0] op, fault_set_t m);
        fma_in_t it;
        it = base_item(op);
        it.fault_mask = m;
        return it;
    endfunction

    function automatic fma_in_t tick_item(logic up, logic [31:0] dropped, logic [11:0] temp,
                                          logic [31:0] now);
        fma_in_t it;
        it = base_item(OP_TICK);
        it.link_up       = up;
        it.dropped_count = dropped;
        it.temp_code     = temp;
        it.now_ms        = now;
        return it;
    endfunction

    function automatic fma_in_t phy_item(logic [15:0] hi, logic [15:0] lo);
        fma_in_t it;
        it = base_item(OP_PHY_CHECK);
        it.phy_word_high = hi;
        it.phy_word_low  = lo;
        return it;
    endfunction

    function automatic fma_in_t read_item(int idx);
        fma_in_t it;
        it = base_item(OP_READ_CNT);
        it.counter_index = 3'(idx);
        return it;
    endfunction

    // Random transaction, biased toward thresholds and matching IDs
    function automatic fma_in_t random_item();
        fma_in_t it;
        int      pick;
        int      t;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            it = base_item(OP_RAISE);
            if ($urandom_range(0, 1) == 0)
                it.fault_mask = fault_set_t'(1 << $urandom_range(0, NUM_FAULTS - 1));
            else if ($urandom_range(0, 9) == 0)
                it.fault_mask = '0;
        end else if (pick < 30) begin
            it = base_item(OP_CLEAR);
        end else if (pick < 65) begin
            it = base_item(OP_TICK);
            it.link_up = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) == 0) gen_clock = $urandom;
            else gen_clock = gen_clock + 32'($urandom_range(0, 1500));
            it.now_ms = gen_clock;
            if ($urandom_range(0, 9) < 4) begin
                t = int'(board.regs.overtemp_raw_limit) + int'($urandom_range(0, 4)) - 2;
                if (t < 0) t = 0;
                if (t > TEMP_CODE_MAX) t = TEMP_CODE_MAX;
                it.temp_code = 12'(t);
            end
            t = $urandom_range(0, 9);
            if (t >= 8) gen_dropped = $urandom;
            else if (t >= 5) gen_dropped = gen_dropped + 32'd1;
            it.dropped_count = gen_dropped;
        end else if (pick < 80) begin
            it = base_item(OP_PHY_CHECK);
            t = $urandom_range(0, 3);
            if (t < 3) begin
                it.phy_word_high = board.regs.phy_id_high_expected;
                it.phy_word_low  = {board.regs.phy_id_low_expected[15:4], it.phy_word_low[3:0]};
            end
            if (t == 2) begin
                if ($urandom_range(0, 1) == 0)
                    it.phy_word_high = it.phy_word_high ^ 16'(1 << $urandom_range(0, 15));
                else
                    it.phy_word_low = it.phy_word_low ^ 16'(1 << $urandom_range(0, 15));
            end
        end else if (pick < 95) begin
            it = base_item(OP_READ_CNT);
        end else begin
            it = base_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
        end
        return it;
    endfunction

    // Offer one input transaction after a gap and wait for it to be taken
    task automatic send_item(fma_in_t item, int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_item(item);
    endtask

    // Stop offering and let every outstanding report come back
    task automatic pause_for_reports();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        board.set_register(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Upper data bits are junk on narrow registers; one write goes to an unmapped index
    task automatic program_registers(fma_cfg_t c);
        write_register(REG_LINK_GRACE, c.link_grace_ms);
        write_register(REG_OVERTEMP_LIM, {20'($urandom), c.overtemp_raw_limit});
        write_register(REG_PHY_ID_HIGH, {16'($urandom), c.phy_id_high_expected});
        write_register(REG_PHY_ID_LOW, {16'($urandom), c.phy_id_low_expected});
        write_register(REG_PHY_ID_LOW + 8'(1 + $urandom_range(0, 251)), $urandom);
    endtask

    task automatic run_phase(int count, int gap_max);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) == 0) pause_for_reports();
            send_item(random_item(), $urandom_range(0, gap_max));
        end
        pause_for_reports();
    endtask

    // Result side: random ready stalls, plus one long hold on request
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            board.check_report(m_data);
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        wait (aresetn === 1'b1);
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("fault_monitor_aggregator_top_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        fma_in_t  directed [$];
        fma_cfg_t plan [6];
        int       gap_plan [6];
        int       stall_plan [6];

        board       = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        gen_clock   = '0;
        gen_dropped = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part under reset register values
        directed.push_back(read_item(FB_CONFIG));
        directed.push_back(mask_item(OP_RAISE, '0));
        directed.push_back(mask_item(OP_CLEAR, '0));
        directed.push_back(mask_item(OP_RAISE, BUS_FAULT | LINK_FAULT));
        directed.push_back(mask_item(OP_RAISE, LINK_FAULT));
        directed.push_back(mask_item(OP_RAISE, ALL_FAULTS));
        directed.push_back(mask_item(OP_CLEAR, ALL_FAULTS));
        directed.push_back(mask_item(OP_RAISE, PHY_FAULT | CONFIG_FAULT));
        // temperature exactly at the limit, then one above
        directed.push_back(tick_item(1'b1, 32'd0, OVERTEMP_LIM_RST, 32'd0));
        directed.push_back(tick_item(1'b0, 32'd5, OVERTEMP_LIM_RST + 12'd1, 32'd100));
        // link down for exactly the grace time, then one more ms
        directed.push_back(tick_item(1'b0, 32'd5, 12'd0, 32'd100 + LINK_GRACE_RST));
        directed.push_back(tick_item(1'b0, 32'd5, 12'hFFF, 32'd101 + LINK_GRACE_RST));
        directed.push_back(tick_item(1'b1, 32'hFFFF_FFFF, 12'hFFF, 32'd102 + LINK_GRACE_RST));
        // down interval that spans the millisecond counter wrap
        directed.push_back(tick_item(1'b0, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FF00));
        directed.push_back(tick_item(1'b0, 32'd0, 12'hFFF, 32'h0000_0C00));
        directed.push_back(phy_item(PHY_ID_HIGH_RST, PHY_ID_LOW_RST | 16'h000F));
        directed.push_back(phy_item(PHY_ID_HIGH_RST ^ 16'h0001, PHY_ID_LOW_RST));
        directed.push_back(phy_item(PHY_ID_HIGH_RST, PHY_ID_LOW_RST ^ 16'h0010));
        directed.push_back(phy_item(16'hFFFF, 16'hFFFF));
        directed.push_back(read_item(FB_BUS));
        directed.push_back(read_item(FB_PHY));
        directed.push_back(read_item(NUM_FAULTS));
        directed.push_back(read_item(NUM_FAULTS + 1));
        for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++)
            directed.push_back(base_item(3'(o)));
        foreach (directed[i]) send_item(directed[i], $urandom_range(0, 3));
        pause_for_reports();

        // Register settings: all zero, all ones, three random, back to reset values
        plan[0] = '0;
        plan[1] = '1;
        for (int p = 2; p < 5; p++) begin
            plan[p].link_grace_ms        = (p == 3) ? $urandom : 32'($urandom_range(0, 400));
            plan[p].overtemp_raw_limit   = 12'($urandom);
            plan[p].phy_id_high_expected = 16'($urandom);
            plan[p].phy_id_low_expected  = 16'($urandom);
        end
        plan[5].link_grace_ms        = LINK_GRACE_RST;
        plan[5].overtemp_raw_limit   = OVERTEMP_LIM_RST;
        plan[5].phy_id_high_expected = PHY_ID_HIGH_RST;
        plan[5].phy_id_low_expected  = PHY_ID_LOW_RST;
        gap_plan   = '{0, 3, 0, 3, 1, 3};
        stall_plan = '{0, 0, 3, 3, 2, 3};

        for (int p = 0; p < 6; p++) begin
            program_registers(plan[p]);
            rx_stall_max = stall_plan[p];
            run_phase(PHASE_ITEMS, gap_plan[p]);
            if (p == 0) begin
                // back-to-back burst against a long result stall
                rx_hold_cycles = HOLD_CYCLES;
                run_phase(BURST_ITEMS, 0);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        board.close_out();
        if (board.errors == 0)
            $display("fault_monitor_aggregator_top_test: done, clean");
        else
            $display("fault_monitor_aggregator_top_test: done, errors");
        $finish;
    end

endmodule
